/* rtl/core/tdc_tof_result_calibrator_macros.svh */
// assertion macros for the tdc time-of-flight calibrator
// used by tdctof_ctrl and tdctof_dp, expects i_clk and i_rst_n in scope
`ifndef TDC_TOF_RESULT_CALIBRATOR_MACROS_SVH
`define TDC_TOF_RESULT_CALIBRATOR_MACROS_SVH

// condition holds in the same cycle
`define TDCTOF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define TDCTOF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tdctof_pkg.sv */
// shared constants, types and command / status structs of the tdc tof calibrator
// no dependencies
`default_nettype none

package tdctof_pkg;

    localparam int STOP_COUNT     = 5;
    localparam int READOUT_BYTES  = 39;
    localparam int BYTES_PER_WORD = 3;
    localparam int NUM_WORDS      = READOUT_BYTES / BYTES_PER_WORD;
    localparam int WORD_W         = 24;
    localparam int ADDR_W         = $clog2(NUM_WORDS);
    localparam int STOP_W         = 3;
    localparam int TOF_W          = 40;
    localparam int LSB_W          = 21;
    localparam int SCALE_W        = 17;
    localparam int DIV_STEPS      = LSB_W;
    localparam int CNT_W          = $clog2(DIV_STEPS);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [STOP_W-1:0] t_stop;

    localparam t_addr TIME0_ADDR = '0;
    localparam t_addr CAL1_ADDR  = t_addr'(NUM_WORDS - 2);
    localparam t_addr CAL2_ADDR  = t_addr'(NUM_WORDS - 1);
    localparam t_stop LAST_STOP  = t_stop'(STOP_COUNT - 1);

    localparam logic [1:0]         PHASE_LAST = 2'(BYTES_PER_WORD - 1);
    localparam logic [LSB_W-1:0]   LSB_NUM    = LSB_W'(1125000);
    localparam logic [SCALE_W-1:0] CLK_SCALE  = SCALE_W'(125000);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CAL1,
        S_DIFF,
        S_TIME0,
        S_DIV,
        S_RD_CLK,
        S_RD_TN,
        S_DT,
        S_MUL,
        S_SUM,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIFF,
        OP_TIME0,
        OP_DIV,
        OP_CLK,
        OP_DT,
        OP_MUL,
        OP_SUM,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op   op;
        logic  shift;
        logic  wr;
        logic  cap_cal2;
        t_addr addr;
        t_stop stop;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic cal_err;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/core/tdctof_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tdctof_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/tdctof_ctrl.sv */
// controller: byte position tracking and the calibration / tof sequence
// depends on tdctof_pkg and tdc_tof_result_calibrator_macros.svh
`default_nettype none
`include "tdc_tof_result_calibrator_macros.svh"

module tdctof_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic              i_frame_start,
    output tdctof_pkg::t_cmd       o_cmd,
    input  wire tdctof_pkg::t_stat i_stat
);

    tdctof_pkg::t_state r_state, n_state;
    logic [1:0]                    r_phase, n_phase;
    tdctof_pkg::t_addr             r_slot, n_slot;
    logic [tdctof_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    tdctof_pkg::t_stop             r_stop, n_stop;

    logic              w_accept;
    logic [1:0]        w_phase;
    tdctof_pkg::t_addr w_slot;
    logic              w_word_done;
    logic              w_frame_done;
    tdctof_pkg::t_cmd  w_cmd;

    assign w_accept     = (r_state == tdctof_pkg::S_IDLE) && i_s_tvalid;
    assign w_phase      = i_frame_start ? 2'd0 : r_phase;
    assign w_slot       = i_frame_start ? '0 : r_slot;
    assign w_word_done  = w_phase == tdctof_pkg::PHASE_LAST;
    assign w_frame_done = w_word_done && (w_slot == tdctof_pkg::CAL2_ADDR);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdctof_pkg::S_IDLE: begin
                if (w_accept && w_frame_done) begin
                    n_state = tdctof_pkg::S_RD_CAL1;
                end
            end
            tdctof_pkg::S_RD_CAL1: n_state = tdctof_pkg::S_DIFF;
            tdctof_pkg::S_DIFF:    n_state = tdctof_pkg::S_TIME0;
            tdctof_pkg::S_TIME0: begin
                n_state = i_stat.cal_err ? tdctof_pkg::S_RD_CLK : tdctof_pkg::S_DIV;
            end
            tdctof_pkg::S_DIV: begin
                if (r_cnt == tdctof_pkg::CNT_W'(tdctof_pkg::DIV_STEPS - 1)) begin
                    n_state = tdctof_pkg::S_RD_CLK;
                end
            end
            tdctof_pkg::S_RD_CLK: n_state = tdctof_pkg::S_RD_TN;
            tdctof_pkg::S_RD_TN:  n_state = tdctof_pkg::S_DT;
            tdctof_pkg::S_DT:     n_state = tdctof_pkg::S_MUL;
            tdctof_pkg::S_MUL:    n_state = tdctof_pkg::S_SUM;
            tdctof_pkg::S_SUM:    n_state = tdctof_pkg::S_OUT;
            tdctof_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = (r_stop == tdctof_pkg::LAST_STOP) ?
                              tdctof_pkg::S_IDLE : tdctof_pkg::S_RD_CLK;
                end
            end
            default: n_state = tdctof_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        w_cmd          = '0;
        w_cmd.op       = tdctof_pkg::OP_NONE;
        w_cmd.stop     = r_stop;
        w_cmd.last     = r_stop == tdctof_pkg::LAST_STOP;
        unique case (r_state)
            tdctof_pkg::S_IDLE: begin
                w_cmd.shift    = w_accept;
                w_cmd.wr       = w_accept && w_word_done;
                w_cmd.cap_cal2 = w_accept && w_frame_done;
                w_cmd.addr     = w_slot;
            end
            tdctof_pkg::S_RD_CAL1: w_cmd.addr = tdctof_pkg::CAL1_ADDR;
            tdctof_pkg::S_DIFF: begin
                w_cmd.op   = tdctof_pkg::OP_DIFF;
                w_cmd.addr = tdctof_pkg::TIME0_ADDR;
            end
            tdctof_pkg::S_TIME0:  w_cmd.op = tdctof_pkg::OP_TIME0;
            tdctof_pkg::S_DIV:    w_cmd.op = tdctof_pkg::OP_DIV;
            tdctof_pkg::S_RD_CLK: w_cmd.addr = {r_stop, 1'b1};
            tdctof_pkg::S_RD_TN: begin
                w_cmd.op   = tdctof_pkg::OP_CLK;
                w_cmd.addr = {3'(r_stop + 3'd1), 1'b0};
            end
            tdctof_pkg::S_DT:  w_cmd.op = tdctof_pkg::OP_DT;
            tdctof_pkg::S_MUL: w_cmd.op = tdctof_pkg::OP_MUL;
            tdctof_pkg::S_SUM: w_cmd.op = tdctof_pkg::OP_SUM;
            tdctof_pkg::S_OUT: begin
                w_cmd.op = i_stat.out_free ? tdctof_pkg::OP_OUT : tdctof_pkg::OP_NONE;
            end
            default: w_cmd.op = tdctof_pkg::OP_NONE;
        endcase
    end

    // counters
    always_comb begin
        n_phase = r_phase;
        n_slot  = r_slot;
        n_cnt   = r_cnt;
        n_stop  = r_stop;
        if (w_accept) begin
            if (w_word_done) begin
                n_phase = 2'd0;
                n_slot  = w_frame_done ? '0 : tdctof_pkg::ADDR_W'(w_slot + 1'b1);
            end else begin
                n_phase = 2'(w_phase + 2'd1);
                n_slot  = w_slot;
            end
        end
        if (r_state == tdctof_pkg::S_TIME0) begin
            n_cnt = '0;
        end else if (r_state == tdctof_pkg::S_DIV) begin
            n_cnt = tdctof_pkg::CNT_W'(r_cnt + 1'b1);
        end
        if (r_state == tdctof_pkg::S_DIFF) begin
            n_stop = '0;
        end else if (w_cmd.op == tdctof_pkg::OP_OUT) begin
            n_stop = tdctof_pkg::STOP_W'(r_stop + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdctof_pkg::S_IDLE;
            r_phase <= '0;
            r_slot  <= '0;
            r_cnt   <= '0;
            r_stop  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_slot  <= n_slot;
            r_cnt   <= n_cnt;
            r_stop  <= n_stop;
        end
    end

    assign o_s_tready = r_state == tdctof_pkg::S_IDLE;
    assign o_cmd      = w_cmd;

    `TDCTOF_ASSERT_NEXT(a_frame_end_starts_cal, w_cmd.cap_cal2,
        r_state == tdctof_pkg::S_RD_CAL1, "last byte did not start calibration")
    `TDCTOF_ASSERT_NOW(a_slot_range, 1'b1, r_slot <= tdctof_pkg::CAL2_ADDR,
        "word slot past the readout")
    `TDCTOF_ASSERT_NOW(a_div_count, r_state == tdctof_pkg::S_DIV,
        r_cnt < tdctof_pkg::CNT_W'(tdctof_pkg::DIV_STEPS), "divider ran too long")

endmodule

`default_nettype wire

/* rtl/core/tdctof_dp.sv */
// datapath: word assembly, word store, lsb divider, tof arithmetic, output register
// depends on tdctof_pkg, tdctof_ram and tdc_tof_result_calibrator_macros.svh
`default_nettype none
`include "tdc_tof_result_calibrator_macros.svh"

module tdctof_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tdctof_pkg::t_cmd                i_cmd,
    output tdctof_pkg::t_stat                    o_stat,
    input  wire logic [7:0]                      i_data_byte,
    input  wire logic                            i_cfg_we,
    input  wire logic [2:0]                      i_cfg_wdata,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [tdctof_pkg::TOF_W-1:0]  o_tof,
    output tdctof_pkg::t_stop                    o_stop_index,
    output logic                                 o_cal_error,
    output logic                                 o_last
);

    localparam int W = tdctof_pkg::WORD_W;
    localparam int CLKP_W = tdctof_pkg::SCALE_W + W;
    localparam int DTP_W = W + 1 + tdctof_pkg::LSB_W + 1;
    localparam int SUM_W = DTP_W + 1;
    localparam int Q_W = SUM_W - 4;
    localparam int TOF_W = tdctof_pkg::TOF_W;

    logic [2:0]                    r_shift;
    logic [15:0]                   r_asm;
    logic [W-1:0]                  r_cal2;
    logic [W-1:0]                  r_time0;
    logic [W-1:0]                  r_div;
    logic [W-1:0]                  r_rem;
    logic [tdctof_pkg::LSB_W-1:0]  r_quo;
    logic                          r_err;
    logic [CLKP_W-1:0]             r_clkp;
    logic signed [W:0]             r_dt;
    logic signed [DTP_W-1:0]       r_dtp;
    logic signed [SUM_W-1:0]       r_sum;
    logic                          r_valid;
    logic signed [TOF_W-1:0]       r_tof;
    tdctof_pkg::t_stop             r_stop;
    logic                          r_last;
    logic                          r_cal_err;

    logic [W-1:0]            w_wdata;
    logic [W-1:0]            w_rdata;
    logic signed [W:0]       w_diff;
    logic                    w_diff_bad;
    logic [W:0]              w_trial;
    logic                    w_fit;
    logic [W-1:0]            w_clk_sh;
    logic signed [DTP_W-1:0] w_dt_ext;
    logic signed [DTP_W-1:0] w_lsb_ext;
    logic signed [Q_W-1:0]   w_q;
    logic                    w_ovf;
    logic signed [TOF_W-1:0] w_sat;
    logic                    w_out_free;

    assign w_wdata = {r_asm, i_data_byte};

    tdctof_ram #(
        .WIDTH (W),
        .DEPTH (tdctof_pkg::NUM_WORDS)
    ) u_words (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (i_cmd.addr),
        .i_wdata (w_wdata),
        .i_raddr (i_cmd.addr),
        .o_rdata (w_rdata)
    );

    assign w_diff     = $signed({1'b0, r_cal2}) - $signed({1'b0, w_rdata});
    assign w_diff_bad = w_diff[W] || (w_diff == '0);
    assign w_trial    = {r_rem, r_quo[tdctof_pkg::LSB_W-1]};
    assign w_fit      = w_trial >= {1'b0, r_div};
    assign w_clk_sh   = w_rdata >> r_shift;
    assign w_dt_ext   = DTP_W'(r_dt);
    assign w_lsb_ext  = DTP_W'($signed({1'b0, r_quo}));
    assign w_q        = r_sum[SUM_W-1:4];
    assign w_ovf      = (w_q[Q_W-1:TOF_W-1] != '0) && (w_q[Q_W-1:TOF_W-1] != '1);
    assign w_sat      = w_ovf ? (w_q[Q_W-1] ? {1'b1, {(TOF_W-1){1'b0}}}
                                            : {1'b0, {(TOF_W-1){1'b1}}})
                              : w_q[TOF_W-1:0];
    assign w_out_free = !r_valid || i_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_asm   <= '0;
            r_quo   <= '0;
            r_err   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_shift <= i_cfg_wdata;
            end
            if (i_cmd.shift) begin
                r_asm <= w_wdata[15:0];
            end
            if (i_cmd.op == tdctof_pkg::OP_DIFF) begin
                r_err <= w_diff_bad;
                r_quo <= w_diff_bad ? '0 : tdctof_pkg::LSB_NUM;
            end else if (i_cmd.op == tdctof_pkg::OP_DIV) begin
                r_quo <= {r_quo[tdctof_pkg::LSB_W-2:0], w_fit};
            end
            if (i_cmd.op == tdctof_pkg::OP_OUT) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_cal2) begin
            r_cal2 <= w_wdata;
        end
        unique case (i_cmd.op)
            tdctof_pkg::OP_DIFF: begin
                r_div <= w_diff[W-1:0];
                r_rem <= '0;
            end
            tdctof_pkg::OP_TIME0: r_time0 <= w_rdata;
            tdctof_pkg::OP_DIV: begin
                r_rem <= w_fit ? W'(w_trial - {1'b0, r_div}) : w_trial[W-1:0];
            end
            tdctof_pkg::OP_CLK: r_clkp <= CLKP_W'(tdctof_pkg::CLK_SCALE) * CLKP_W'(w_clk_sh);
            tdctof_pkg::OP_DT:  r_dt <= $signed({1'b0, r_time0}) - $signed({1'b0, w_rdata});
            tdctof_pkg::OP_MUL: r_dtp <= w_dt_ext * w_lsb_ext;
            tdctof_pkg::OP_SUM: r_sum <= $signed({{(SUM_W-CLKP_W){1'b0}}, r_clkp})
                                         + SUM_W'(r_dtp);
            tdctof_pkg::OP_OUT: begin
                r_tof     <= r_err ? '0 : w_sat;
                r_stop    <= i_cmd.stop;
                r_last    <= i_cmd.last;
                r_cal_err <= r_err;
            end
            default: ;
        endcase
    end

    assign o_stat.cal_err  = r_err;
    assign o_stat.out_free = w_out_free;
    assign o_valid         = r_valid;
    assign o_tof           = r_tof;
    assign o_stop_index    = r_stop;
    assign o_cal_error     = r_cal_err;
    assign o_last          = r_last;

    `TDCTOF_ASSERT_NOW(a_no_div_on_err, i_cmd.op == tdctof_pkg::OP_DIV, !r_err,
        "divider stepped with a bad calibration")
    `TDCTOF_ASSERT_NOW(a_load_when_free, i_cmd.op == tdctof_pkg::OP_OUT, w_out_free,
        "result loaded over a pending one")
    `TDCTOF_ASSERT_NEXT(a_load_sets_valid, i_cmd.op == tdctof_pkg::OP_OUT, r_valid,
        "loaded result not offered")

endmodule

`default_nettype wire

/* rtl/core/tdc_tof_result_calibrator.sv */
// top level of the tdc time-of-flight calibrator
// depends on tdctof_pkg, tdctof_ctrl, tdctof_dp (which holds tdctof_ram)
//
// input stream: one readout byte per request, s_tuser high on the first byte
// of a readout. 39 bytes make a readout: five time / clock-count pairs, time 6,
// calibration 1 and calibration 2, 24-bit words, most significant byte first.
// bytes are taken one per cycle while no readout is being computed.
// after the 39th byte the block reads cal1, divides 1125000 by cal2 - cal1
// in a bit-serial divider (skipped on a bad calibration), then runs each
// stop through the shared multiply / add path (one word-store read port):
// read its clock count and time, take the time difference, multiply by the
// lsb, add the scaled clock count and load the output register. s_tready is
// low from the last byte until the fifth result is loaded into the output
// register.
// output stream: five results per readout, m_tlast on the fifth, m_tuser set
// when the calibration difference was not positive (tof is then zero).
// a stalled receiver holds the output register and pauses the sequence.
// reset clears position, assembler, lsb and average_shift; the word store is not
// cleared. the user writes average_shift (i_cfg_we) only while idle; not enforced.
`default_nettype none

module tdc_tof_result_calibrator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata,   // average_shift
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] data_byte
    input  wire logic        s_tuser,       // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,       // [39:0] tof, [42:40] stop_index, zero above
    output logic             m_tuser,       // [0] cal_error
    output logic             m_tlast
);

    tdctof_pkg::t_cmd  w_cmd;
    tdctof_pkg::t_stat w_stat;
    logic signed [tdctof_pkg::TOF_W-1:0] w_tof;
    tdctof_pkg::t_stop w_stop;

    tdctof_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_frame_start (s_tuser),
        .o_cmd         (w_cmd),
        .i_stat        (w_stat)
    );

    tdctof_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_data_byte  (s_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_tof        (w_tof),
        .o_stop_index (w_stop),
        .o_cal_error  (m_tuser),
        .o_last       (m_tlast)
    );

    assign m_tdata = {5'b0, w_stop, w_tof};

endmodule

`default_nettype wire
